FILE: hw/rtl/csfa_pkg.sv
// Package with the beat types, direction codes and corner table of the contour accumulator.
`timescale 1ns / 1ps

package csfa_pkg;

  localparam int unsigned CoordBits     = 12;
  localparam int unsigned MaxPointsLog2 = 20;

  localparam int unsigned CoordFieldW = 12;
  localparam int unsigned CntFieldW   = 21;
  localparam int unsigned AreaW       = 28;
  localparam int unsigned SumW        = 32;
  localparam int unsigned CntW        = MaxPointsLog2 + 1;
  localparam int unsigned CornerW     = 4;

  localparam logic [CntW-1:0] PointLimit = {1'b1, {MaxPointsLog2{1'b0}}};

  typedef enum logic [3:0] {
    DIR_NONE  = 4'd0,
    DIR_NX_NY = 4'd1,
    DIR_NX_ZY = 4'd2,
    DIR_NX_PY = 4'd3,
    DIR_ZX_PY = 4'd4,
    DIR_PX_PY = 4'd5,
    DIR_PX_ZY = 4'd6,
    DIR_PX_NY = 4'd7,
    DIR_ZX_NY = 4'd8
  } dir_e;

  typedef enum logic [1:0] {
    STATUS_OK       = 2'd0,
    STATUS_REPEAT   = 2'd1,
    STATUS_OVERFLOW = 2'd2
  } status_e;

  typedef struct packed {
    logic [CoordFieldW-1:0] x_coord;
    logic [CoordFieldW-1:0] y_coord;
    logic                   last_point;
  } csfa_in_t;

  typedef struct packed {
    logic signed [AreaW-1:0] area_eighths;
    logic [CntFieldW-1:0]    straight_steps;
    logic [CntFieldW-1:0]    diagonal_steps;
    logic [CntFieldW-1:0]    point_count;
    logic [CoordFieldW-1:0]  min_x;
    logic [CoordFieldW-1:0]  max_x;
    logic [CoordFieldW-1:0]  min_y;
    logic [CoordFieldW-1:0]  max_y;
    logic [SumW-1:0]         sum_x;
    logic [SumW-1:0]         sum_y;
    status_e                 status;
  } csfa_out_t;

  typedef struct packed {
    dir_e             code;
    logic [AreaW-1:0] term;
    logic             diag;
  } step_t;

  localparam logic [CornerW-1:0] CornerTab [9][9] = '{
    '{4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0},
    '{4'd0, 4'd4, 4'd5, 4'd6, 4'd7, 4'd8, 4'd0, 4'd2, 4'd3},
    '{4'd0, 4'd3, 4'd4, 4'd5, 4'd6, 4'd7, 4'd8, 4'd0, 4'd0},
    '{4'd0, 4'd2, 4'd3, 4'd4, 4'd5, 4'd6, 4'd7, 4'd8, 4'd0},
    '{4'd0, 4'd0, 4'd0, 4'd3, 4'd4, 4'd5, 4'd6, 4'd7, 4'd8},
    '{4'd0, 4'd8, 4'd0, 4'd2, 4'd3, 4'd4, 4'd5, 4'd6, 4'd7},
    '{4'd0, 4'd7, 4'd8, 4'd0, 4'd0, 4'd3, 4'd4, 4'd5, 4'd6},
    '{4'd0, 4'd6, 4'd7, 4'd8, 4'd0, 4'd2, 4'd3, 4'd4, 4'd5},
    '{4'd0, 4'd5, 4'd6, 4'd7, 4'd8, 4'd0, 4'd0, 4'd3, 4'd4}
  };

  // The trapezoid term is 8*y of the end point, less 4 going up and plus 4 going down,
  // negated for steps toward smaller x and zero for vertical steps.
  function automatic step_t classify(logic [CoordBits-1:0] ax, logic [CoordBits-1:0] ay,
                                     logic [CoordBits-1:0] bx, logic [CoordBits-1:0] by);
    step_t            s;
    logic [AreaW-1:0] t;
    t = AreaW'({by, 3'b000});
    if (by > ay) begin
      t = t - AreaW'(4);
    end else if (by < ay) begin
      t = t + AreaW'(4);
    end
    s.diag = (bx != ax) && (by != ay);
    if (bx > ax) begin
      s.code = (by > ay) ? DIR_PX_PY : ((by < ay) ? DIR_PX_NY : DIR_PX_ZY);
      s.term = t;
    end else if (bx < ax) begin
      s.code = (by > ay) ? DIR_NX_PY : ((by < ay) ? DIR_NX_NY : DIR_NX_ZY);
      s.term = AreaW'(0) - t;
    end else begin
      s.code = (by > ay) ? DIR_ZX_PY : ((by < ay) ? DIR_ZX_NY : DIR_NONE);
      s.term = AreaW'(0);
    end
    return s;
  endfunction

  function automatic logic [AreaW-1:0] corner(dir_e a, dir_e b);
    logic [AreaW-1:0] c;
    if (a > DIR_ZX_NY || b > DIR_ZX_NY) begin
      c = AreaW'(0);
    end else begin
      c = AreaW'(CornerTab[a][b]);
    end
    return c;
  endfunction

endpackage

FILE: hw/rtl/contour_shape_feature_accumulator_unit.sv
// Contour area, step count, bounding box and coordinate sum accumulator for closed chains.
// Order: a point beat is registered in the input register on acceptance and folded into the
// chain state when it advances; a last point's advance loads the result beat into out_q.
// Throughput: one point per cycle; a last point waits in the input register only while an
// earlier result beat is still not taken.
// Reset: rst_ni clears the handshake state and all chain accumulators at once.
`timescale 1ns / 1ps

module contour_shape_feature_accumulator_unit import csfa_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  csfa_in_t  in_data_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output csfa_out_t out_data_o
);

  localparam logic [CoordBits-1:0] CoordMax = {CoordBits{1'b1}};

  csfa_in_t  in_q;
  logic      in_vld_q;
  csfa_out_t out_q, out_d;
  logic      out_vld_q;
  logic      advance;

  logic [CoordBits-1:0] first_x_q, first_y_q, prev_x_q, prev_y_q;
  logic [CoordBits-1:0] first_x_d, first_y_d, prev_x_d, prev_y_d;
  logic [CoordBits-1:0] min_x_q, max_x_q, min_y_q, max_y_q;
  logic [CoordBits-1:0] min_x_d, max_x_d, min_y_d, max_y_d;
  dir_e                 first_dir_q, prev_dir_q, first_dir_d, prev_dir_d;
  logic [AreaW-1:0]     area_q, area_d;
  logic [CntW-1:0]      straight_q, straight_d, diagonal_q, diagonal_d, cnt_q, cnt_d;
  logic [SumW-1:0]      sum_x_q, sum_y_q, sum_x_d, sum_y_d;
  status_e              err_q, err_d;

  logic [CoordBits-1:0] x, y;
  step_t                stp, cls;

  assign advance    = in_vld_q && (!in_q.last_point || !out_vld_q || out_ready_i);
  assign in_ready_o = !in_vld_q || advance;

  always_comb begin
    x = in_q.x_coord[CoordBits-1:0];
    y = in_q.y_coord[CoordBits-1:0];
    first_x_d   = first_x_q;
    first_y_d   = first_y_q;
    prev_x_d    = prev_x_q;
    prev_y_d    = prev_y_q;
    first_dir_d = first_dir_q;
    prev_dir_d  = prev_dir_q;
    area_d      = area_q;
    straight_d  = straight_q;
    diagonal_d  = diagonal_q;
    cnt_d       = cnt_q;
    min_x_d     = min_x_q;
    max_x_d     = max_x_q;
    min_y_d     = min_y_q;
    max_y_d     = max_y_q;
    sum_x_d     = sum_x_q;
    sum_y_d     = sum_y_q;
    err_d       = err_q;

    stp = classify(prev_x_q, prev_y_q, x, y);

    if (cnt_q >= PointLimit) begin
      if (err_q == STATUS_OK) begin
        err_d = STATUS_OVERFLOW;
      end
    end else begin
      if (cnt_q == '0) begin
        first_x_d = x;
        first_y_d = y;
      end else if (err_q == STATUS_OK) begin
        if (stp.code == DIR_NONE) begin
          err_d = STATUS_REPEAT;
        end else begin
          area_d = area_q + stp.term;
          if (stp.diag) begin
            diagonal_d = diagonal_q + CntW'(1);
          end else begin
            straight_d = straight_q + CntW'(1);
          end
          if (cnt_q == CntW'(1)) begin
            first_dir_d = stp.code;
          end else begin
            area_d = area_d + corner(prev_dir_q, stp.code);
          end
          prev_dir_d = stp.code;
        end
      end
      prev_x_d = x;
      prev_y_d = y;
      if (x < min_x_q) min_x_d = x;
      if (x > max_x_q) max_x_d = x;
      if (y < min_y_q) min_y_d = y;
      if (y > max_y_q) max_y_d = y;
      sum_x_d = sum_x_q + SumW'(x);
      sum_y_d = sum_y_q + SumW'(y);
      cnt_d   = cnt_q + CntW'(1);
    end

    // The closing step runs from the newest point back to the first one.
    cls = classify(prev_x_d, prev_y_d, first_x_d, first_y_d);

    if (in_q.last_point && err_d == STATUS_OK) begin
      if (cls.code == DIR_NONE) begin
        err_d = STATUS_REPEAT;
      end else begin
        area_d = area_d + cls.term;
        if (cls.diag) begin
          diagonal_d = diagonal_d + CntW'(1);
        end else begin
          straight_d = straight_d + CntW'(1);
        end
        if (cnt_d >= CntW'(2)) begin
          area_d = area_d + corner(prev_dir_d, cls.code) + corner(cls.code, first_dir_d);
        end
      end
    end

    out_d.area_eighths   = (err_d == STATUS_OK) ? area_d : '0;
    out_d.straight_steps = (err_d == STATUS_OK) ? CntFieldW'(straight_d) : '0;
    out_d.diagonal_steps = (err_d == STATUS_OK) ? CntFieldW'(diagonal_d) : '0;
    out_d.point_count    = CntFieldW'(cnt_d);
    out_d.min_x          = CoordFieldW'(min_x_d);
    out_d.max_x          = CoordFieldW'(max_x_d);
    out_d.min_y          = CoordFieldW'(min_y_d);
    out_d.max_y          = CoordFieldW'(max_y_d);
    out_d.sum_x          = sum_x_d;
    out_d.sum_y          = sum_y_d;
    out_d.status         = err_d;

    if (in_q.last_point) begin
      first_x_d   = '0;
      first_y_d   = '0;
      prev_x_d    = '0;
      prev_y_d    = '0;
      first_dir_d = DIR_NONE;
      prev_dir_d  = DIR_NONE;
      area_d      = '0;
      straight_d  = '0;
      diagonal_d  = '0;
      cnt_d       = '0;
      min_x_d     = CoordMax;
      max_x_d     = '0;
      min_y_d     = CoordMax;
      max_y_d     = '0;
      sum_x_d     = '0;
      sum_y_d     = '0;
      err_d       = STATUS_OK;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      if (in_ready_o) begin
        in_vld_q <= in_valid_i;
      end
      if (advance && in_q.last_point) begin
        out_vld_q <= 1'b1;
      end else if (out_ready_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      in_q <= in_data_i;
    end
    if (advance && in_q.last_point) begin
      out_q <= out_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      first_x_q   <= '0;
      first_y_q   <= '0;
      prev_x_q    <= '0;
      prev_y_q    <= '0;
      first_dir_q <= DIR_NONE;
      prev_dir_q  <= DIR_NONE;
      area_q      <= '0;
      straight_q  <= '0;
      diagonal_q  <= '0;
      cnt_q       <= '0;
      min_x_q     <= CoordMax;
      max_x_q     <= '0;
      min_y_q     <= CoordMax;
      max_y_q     <= '0;
      sum_x_q     <= '0;
      sum_y_q     <= '0;
      err_q       <= STATUS_OK;
    end else if (advance) begin
      first_x_q   <= first_x_d;
      first_y_q   <= first_y_d;
      prev_x_q    <= prev_x_d;
      prev_y_q    <= prev_y_d;
      first_dir_q <= first_dir_d;
      prev_dir_q  <= prev_dir_d;
      area_q      <= area_d;
      straight_q  <= straight_d;
      diagonal_q  <= diagonal_d;
      cnt_q       <= cnt_d;
      min_x_q     <= min_x_d;
      max_x_q     <= max_x_d;
      min_y_q     <= min_y_d;
      max_y_q     <= max_y_d;
      sum_x_q     <= sum_x_d;
      sum_y_q     <= sum_y_d;
      err_q       <= err_d;
    end
  end

  assign out_valid_o = out_vld_q;
  assign out_data_o  = out_q;

endmodule

FILE: hw/rtl/csfa_checker.sv
// Port-level checker for the contour accumulator, bound to its top level.
`timescale 1ns / 1ps

module csfa_checker import csfa_pkg::*; (
  input logic      clk_i,
  input logic      rst_ni,
  input logic      in_ready_o,
  input logic      out_valid_o,
  input logic      out_ready_i,
  input csfa_out_t out_data_o
);

  logic [CntFieldW:0] steps_total;

  assign steps_total = (CntFieldW + 1)'(out_data_o.straight_steps)
                     + (CntFieldW + 1)'(out_data_o.diagonal_steps);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("Result beat dropped or changed while stalled.");

  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.status != STATUS_OK |->
      out_data_o.area_eighths == '0 && out_data_o.straight_steps == '0 &&
      out_data_o.diagonal_steps == '0)
    else $error("Error result carries nonzero area or step counts.");

  a_steps_match: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.status == STATUS_OK |->
      steps_total == (CntFieldW + 1)'(out_data_o.point_count))
    else $error("Closed chain step count differs from its point count.");

  a_bbox_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_data_o.min_x <= out_data_o.max_x &&
      out_data_o.min_y <= out_data_o.max_y)
    else $error("Bounding box minimum exceeds its maximum.");

  a_ready_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> in_ready_o)
    else $error("Input stalled while the result register is empty.");

endmodule

bind contour_shape_feature_accumulator_unit csfa_checker u_csfa_checker (.*);

FILE: tb/tb_contour_shape_feature_accumulator_unit.sv
// Self-checking testbench for the contour area, step, bounding box and coordinate sum unit.
`timescale 1ns / 1ps

module tb_contour_shape_feature_accumulator_unit;
  import csfa_pkg::*;

  typedef enum logic [1:0] {
    PACE_FREE,
    PACE_SEND_IDLE,
    PACE_RECV_STALL,
    PACE_BOTH
  } pace_e;

  localparam int COORD_MAX = (1 << CoordBits) - 1;

  localparam logic [3:0] TURN_FIX [9][9] = '{
    '{4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0},
    '{4'd0, 4'd4, 4'd5, 4'd6, 4'd7, 4'd8, 4'd0, 4'd2, 4'd3},
    '{4'd0, 4'd3, 4'd4, 4'd5, 4'd6, 4'd7, 4'd8, 4'd0, 4'd0},
    '{4'd0, 4'd2, 4'd3, 4'd4, 4'd5, 4'd6, 4'd7, 4'd8, 4'd0},
    '{4'd0, 4'd0, 4'd0, 4'd3, 4'd4, 4'd5, 4'd6, 4'd7, 4'd8},
    '{4'd0, 4'd8, 4'd0, 4'd2, 4'd3, 4'd4, 4'd5, 4'd6, 4'd7},
    '{4'd0, 4'd7, 4'd8, 4'd0, 4'd0, 4'd3, 4'd4, 4'd5, 4'd6},
    '{4'd0, 4'd6, 4'd7, 4'd8, 4'd0, 4'd2, 4'd3, 4'd4, 4'd5},
    '{4'd0, 4'd5, 4'd6, 4'd7, 4'd8, 4'd0, 4'd0, 4'd3, 4'd4}
  };

  logic      clk_i = 1'b0;
  logic      rst_ni = 1'b0;
  logic      in_valid_i = 1'b0;
  logic      in_ready_o;
  csfa_in_t  in_data_i = '0;
  logic      out_valid_o;
  logic      out_ready_i = 1'b0;
  csfa_out_t out_data_o;

  pace_e     pace = PACE_FREE;
  csfa_in_t  pending_points[$];
  csfa_out_t expected_features[$];
  int        points_queued = 0;
  int        points_taken = 0;
  int        mismatches = 0;

  logic [CoordFieldW-1:0] org_x, org_y, last_x, last_y;
  logic [CoordFieldW-1:0] lo_x, hi_x, lo_y, hi_y;
  dir_e                   open_dir, run_dir;
  logic [AreaW-1:0]       area_sum;
  logic [CntW-1:0]        n_straight, n_diag, n_pts;
  logic [SumW-1:0]        tot_x, tot_y;
  status_e                chain_status;

  contour_shape_feature_accumulator_unit uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  function automatic bit hold_send();
    bit h;
    case (pace)
      PACE_SEND_IDLE: h = ($urandom_range(0, 99) < 60);
      PACE_BOTH:      h = ($urandom_range(0, 99) < 7);
      default:        h = 1'b0;
    endcase
    return h;
  endfunction

  function automatic bit hold_recv();
    bit h;
    case (pace)
      PACE_RECV_STALL: h = ($urandom_range(0, 99) < 60);
      PACE_BOTH:       h = ($urandom_range(0, 99) < 7);
      default:         h = 1'b0;
    endcase
    return h;
  endfunction

  function automatic dir_e heading(input logic [CoordFieldW-1:0] ax, input logic [CoordFieldW-1:0] ay,
                                   input logic [CoordFieldW-1:0] bx, input logic [CoordFieldW-1:0] by,
                                   output logic [AreaW-1:0] term);
    logic [AreaW-1:0] t;
    dir_e             d;
    t = AreaW'({by, 3'b000});
    if (by > ay) begin
      t = t - AreaW'(4);
    end else if (by < ay) begin
      t = t + AreaW'(4);
    end
    if (bx > ax) begin
      d = (by > ay) ? DIR_PX_PY : ((by < ay) ? DIR_PX_NY : DIR_PX_ZY);
      term = t;
    end else if (bx < ax) begin
      d = (by > ay) ? DIR_NX_PY : ((by < ay) ? DIR_NX_NY : DIR_NX_ZY);
      term = AreaW'(0) - t;
    end else begin
      d = (by > ay) ? DIR_ZX_PY : ((by < ay) ? DIR_ZX_NY : DIR_NONE);
      term = '0;
    end
    return d;
  endfunction

  function automatic bit slanted(input dir_e d);
    bit s;
    case (d)
      DIR_NX_NY, DIR_NX_PY, DIR_PX_PY, DIR_PX_NY: s = 1'b1;
      default:                                    s = 1'b0;
    endcase
    return s;
  endfunction

  function automatic logic [AreaW-1:0] turn(input dir_e a, input dir_e b);
    return AreaW'(TURN_FIX[a][b]);
  endfunction

  task automatic restart_chain();
    org_x = '0;
    org_y = '0;
    last_x = '0;
    last_y = '0;
    open_dir = DIR_NONE;
    run_dir = DIR_NONE;
    area_sum = '0;
    n_straight = '0;
    n_diag = '0;
    n_pts = '0;
    lo_x = '1;
    hi_x = '0;
    lo_y = '1;
    hi_y = '0;
    tot_x = '0;
    tot_y = '0;
    chain_status = STATUS_OK;
  endtask

  task automatic take_step(input dir_e d, input logic [AreaW-1:0] term);
    area_sum = area_sum + term;
    if (slanted(d)) begin
      n_diag = n_diag + CntW'(1);
    end else begin
      n_straight = n_straight + CntW'(1);
    end
  endtask

  task automatic absorb(input csfa_in_t p);
    logic [CoordFieldW-1:0] x, y;
    logic [AreaW-1:0]       term;
    dir_e                   d;
    csfa_out_t              res;
    x = p.x_coord;
    y = p.y_coord;
    if (n_pts >= PointLimit) begin
      if (chain_status == STATUS_OK) begin
        chain_status = STATUS_OVERFLOW;
      end
    end else begin
      if (n_pts == '0) begin
        org_x = x;
        org_y = y;
      end else if (chain_status == STATUS_OK) begin
        d = heading(last_x, last_y, x, y, term);
        if (d == DIR_NONE) begin
          chain_status = STATUS_REPEAT;
        end else begin
          take_step(d, term);
          if (n_pts == CntW'(1)) begin
            open_dir = d;
          end else begin
            area_sum = area_sum + turn(run_dir, d);
          end
          run_dir = d;
        end
      end
      last_x = x;
      last_y = y;
      if (x < lo_x) lo_x = x;
      if (x > hi_x) hi_x = x;
      if (y < lo_y) lo_y = y;
      if (y > hi_y) hi_y = y;
      tot_x = tot_x + SumW'(x);
      tot_y = tot_y + SumW'(y);
      n_pts = n_pts + CntW'(1);
    end
    if (p.last_point) begin
      if (chain_status == STATUS_OK) begin
        d = heading(last_x, last_y, org_x, org_y, term);
        if (d == DIR_NONE) begin
          chain_status = STATUS_REPEAT;
        end else begin
          take_step(d, term);
          if (n_pts >= CntW'(2)) begin
            area_sum = area_sum + turn(run_dir, d) + turn(d, open_dir);
          end
        end
      end
      res.area_eighths   = (chain_status == STATUS_OK) ? area_sum : '0;
      res.straight_steps = (chain_status == STATUS_OK) ? n_straight : '0;
      res.diagonal_steps = (chain_status == STATUS_OK) ? n_diag : '0;
      res.point_count    = n_pts;
      res.min_x          = lo_x;
      res.max_x          = hi_x;
      res.min_y          = lo_y;
      res.max_y          = hi_y;
      res.sum_x          = tot_x;
      res.sum_y          = tot_y;
      res.status         = chain_status;
      expected_features.push_back(res);
      restart_chain();
    end
  endtask

  task automatic note_mismatch(input string what, input logic [SumW-1:0] got,
                               input logic [SumW-1:0] want);
    mismatches++;
    $display("%0t mismatch on %s: got %0h, want %0h", $realtime, what, got, want);
  endtask

  task automatic compare_features(input csfa_out_t got);
    csfa_out_t want;
    if (expected_features.size() == 0) begin
      note_mismatch("result beat with nothing pending", '0, '0);
    end else begin
      want = expected_features.pop_front();
      if (got.area_eighths !== want.area_eighths)
        note_mismatch("area_eighths", got.area_eighths, want.area_eighths);
      if (got.straight_steps !== want.straight_steps)
        note_mismatch("straight_steps", got.straight_steps, want.straight_steps);
      if (got.diagonal_steps !== want.diagonal_steps)
        note_mismatch("diagonal_steps", got.diagonal_steps, want.diagonal_steps);
      if (got.point_count !== want.point_count)
        note_mismatch("point_count", got.point_count, want.point_count);
      if (got.min_x !== want.min_x) note_mismatch("min_x", got.min_x, want.min_x);
      if (got.max_x !== want.max_x) note_mismatch("max_x", got.max_x, want.max_x);
      if (got.min_y !== want.min_y) note_mismatch("min_y", got.min_y, want.min_y);
      if (got.max_y !== want.max_y) note_mismatch("max_y", got.max_y, want.max_y);
      if (got.sum_x !== want.sum_x) note_mismatch("sum_x", got.sum_x, want.sum_x);
      if (got.sum_y !== want.sum_y) note_mismatch("sum_y", got.sum_y, want.sum_y);
      if (got.status !== want.status) note_mismatch("status", got.status, want.status);
    end
  endtask

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else begin
      if (in_valid_i && in_ready_o) begin
        absorb(in_data_i);
        points_taken++;
      end
      if (!in_valid_i || in_ready_o) begin
        if (pending_points.size() != 0 && !hold_send()) begin
          in_valid_i <= 1'b1;
          in_data_i  <= pending_points.pop_front();
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        compare_features(out_data_o);
      end
      out_ready_i <= !hold_recv();
    end
  end

  task automatic queue_point(input int x, input int y, input bit last);
    csfa_in_t p;
    p.x_coord    = CoordFieldW'(x);
    p.y_coord    = CoordFieldW'(y);
    p.last_point = last;
    pending_points.push_back(p);
    points_queued++;
  endtask

  task automatic wander(inout int x, inout int y);
    int dx, dy;
    dx = 0;
    dy = 0;
    while (dx == 0 && dy == 0) begin
      dx = int'($urandom_range(0, 2)) - 1;
      dy = int'($urandom_range(0, 2)) - 1;
    end
    if (x + dx < 0 || x + dx > COORD_MAX) dx = -dx;
    if (y + dy < 0 || y + dy > COORD_MAX) dy = -dy;
    x = x + dx;
    y = y + dy;
  endtask

  task automatic queue_walk(input int len, input bit dup, input bit shut);
    int x, y, x0, y0, k, hit;
    x = $urandom_range(0, COORD_MAX);
    y = $urandom_range(0, COORD_MAX);
    x0 = x;
    y0 = y;
    hit = dup ? $urandom_range(0, len - 2) : -1;
    for (k = 0; k < len; k++) begin
      queue_point(x, y, (k == len - 1) && !shut);
      if (k == hit) queue_point(x, y, 1'b0);
      wander(x, y);
    end
    if (shut) queue_point(x0, y0, 1'b1);
  endtask

  initial begin
    int k, n, ph, start;
    restart_chain();
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    queue_point(10, 10, 0);
    queue_point(11, 10, 0);
    queue_point(11, 11, 0);
    queue_point(10, 11, 1);
    queue_point(100, 100, 0);
    queue_point(101, 101, 0);
    queue_point(100, 102, 0);
    queue_point(99, 101, 1);
    queue_point(0, 0, 0);
    queue_point(COORD_MAX, 0, 0);
    queue_point(COORD_MAX, COORD_MAX, 0);
    queue_point(0, COORD_MAX, 1);
    queue_point(5, 7, 1);
    queue_point(3, 3, 0);
    queue_point(3, 3, 0);
    queue_point(4, 4, 1);
    queue_point(20, 20, 0);
    queue_point(21, 20, 0);
    queue_point(20, 20, 1);
    queue_point(50, 50, 0);
    queue_point(51, 51, 1);

    for (ph = 0; ph < 4; ph++) begin
      while (pending_points.size() != 0) @(posedge clk_i);
      pace = pace_e'(ph);
      start = points_queued;
      while (points_queued - start < 240) begin
        case ($urandom_range(0, 9))
          6: begin
            n = $urandom_range(2, 12);
            for (k = 0; k < n; k++) begin
              queue_point($urandom_range(0, COORD_MAX), $urandom_range(0, COORD_MAX), k == n - 1);
            end
          end
          7: queue_walk($urandom_range(2, 16), 1'b1, 1'b0);
          8: queue_walk($urandom_range(2, 16), 1'b0, 1'b1);
          9: begin
            n = $urandom_range(1, 4);
            for (k = 0; k < n; k++) begin
              queue_point($urandom_range(0, 1) ? COORD_MAX : 0,
                          $urandom_range(0, 1) ? COORD_MAX : 0, k == n - 1);
            end
          end
          default: queue_walk($urandom_range(2, 24), 1'b0, 1'b0);
        endcase
      end
    end

    while (points_taken != points_queued) @(posedge clk_i);
    for (k = 0; k < 20000 && expected_features.size() != 0; k++) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    if (expected_features.size() != 0) begin
      note_mismatch("results never delivered", expected_features.size(), '0);
    end
    if (mismatches == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  initial begin
    #50_000_000;
    $display("Regression FAIL");
    $finish;
  end

endmodule

FILE: sim.f
hw/rtl/csfa_pkg.sv
hw/rtl/contour_shape_feature_accumulator_unit.sv
hw/rtl/csfa_checker.sv
tb/tb_contour_shape_feature_accumulator_unit.sv
